// ----- hdl/clrp_pkg.sv -----
// Shared types and constants of the CPU list range parser.
`timescale 1ns / 1ps
package clrp_pkg;

	localparam int VAL_W     = 10;
	localparam int MASK_W    = 64;
	localparam int CORES_DEF = 64;

	localparam logic [7:0] SYM_ZERO   = 8'h30;
	localparam logic [7:0] SYM_NINE   = 8'h39;
	localparam logic [7:0] SYM_COMMA  = 8'h2C;
	localparam logic [7:0] SYM_HYPHEN = 8'h2D;
	localparam logic [7:0] SYM_SPACE  = 8'h20;

	localparam logic [VAL_W-1:0] ACC_MAX  = 10'd1023;
	localparam logic [3:0]       DEC_BASE = 4'd10;

	typedef struct packed {
		logic [7:0] symbol;
		logic       end_of_list;
	} item_t;

	typedef struct packed {
		logic [VAL_W-1:0]  range_first;
		logic [VAL_W-1:0]  range_final;
		logic [MASK_W-1:0] core_mask;
		logic              out_of_range;
		logic              list_done;
	} result_t;

endpackage

// ----- hdl/clrp_in_stage.sv -----
// Input register stage of the CPU list range parser.
`timescale 1ns / 1ps
module clrp_in_stage
	import clrp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	input  item_t item,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	logic vld_s1;

	assign item_ready = !vld_s1 || advance;
	assign valid_s1   = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item_ready) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

endmodule

// ----- hdl/clrp_core.sv -----
// Parser state, character decode and range commit into the core bitmap.
`timescale 1ns / 1ps
module clrp_core
	import clrp_pkg::*;
#(
	parameter int CORES = CORES_DEF
)
(
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item_s1,
	input  logic    fire,
	output logic    has_result,
	output result_t res
);

	localparam logic [VAL_W-1:0]  CORES_V    = VAL_W'(CORES);
	localparam logic [MASK_W-1:0] VALID_BITS =
		(CORES >= MASK_W) ? {MASK_W{1'b1}} : ((MASK_W'(1) << CORES) - MASK_W'(1));

	logic [VAL_W-1:0]  acc_q, start_q, end_q;
	logic              pend_q;
	logic [MASK_W-1:0] marked_q;

	logic              is_digit, is_hyphen, is_sep, eol;
	logic [13:0]       prod;
	logic [VAL_W-1:0]  acc_dig;
	logic [VAL_W-1:0]  acc_n, start_n, end_n;
	logic              pend_n;
	logic [VAL_W-1:0]  first, last;
	logic [MASK_W-1:0] span;
	logic [MASK_W-1:0] mask_n;

	always_comb begin
		is_digit  = (item_s1.symbol >= SYM_ZERO) && (item_s1.symbol <= SYM_NINE);
		is_hyphen = (item_s1.symbol == SYM_HYPHEN);
		is_sep    = (item_s1.symbol == SYM_COMMA) || (item_s1.symbol == SYM_SPACE);
		eol       = item_s1.end_of_list;

		prod    = 14'(acc_q) * 14'(DEC_BASE) + 14'(item_s1.symbol - SYM_ZERO);
		acc_dig = (prod > 14'(ACC_MAX)) ? ACC_MAX : prod[VAL_W-1:0];

		acc_n   = acc_q;
		start_n = start_q;
		end_n   = end_q;
		pend_n  = pend_q;
		// other characters leave the parser state untouched
		if (is_digit) begin
			acc_n = acc_dig;
			if (pend_q) begin
				end_n = acc_dig;
			end else begin
				start_n = acc_dig;
			end
		end else if (is_hyphen) begin
			acc_n  = '0;
			pend_n = 1'b1;
		end else if (is_sep) begin
			acc_n = '0;
		end

		first = start_n;
		last  = pend_n ? end_n : start_n;

		// bits past CORES stay clear; a reversed range matches no bit
		for (int i = 0; i < MASK_W; i++) begin
			span[i] = VALID_BITS[i] && (first <= VAL_W'(i)) && (VAL_W'(i) <= last);
		end
		mask_n = marked_q | span;

		has_result       = is_sep || eol;
		res.range_first  = first;
		res.range_final  = last;
		res.core_mask    = mask_n;
		res.out_of_range = (first <= last) && (last >= CORES_V);
		res.list_done    = eol;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			start_q  <= '0;
			end_q    <= '0;
			pend_q   <= 1'b0;
			marked_q <= '0;
		end else if (fire) begin
			if (eol) begin
				acc_q    <= '0;
				start_q  <= '0;
				end_q    <= '0;
				pend_q   <= 1'b0;
				marked_q <= '0;
			end else begin
				acc_q   <= acc_n;
				start_q <= start_n;
				end_q   <= end_n;
				if (is_sep) begin
					pend_q   <= 1'b0;
					marked_q <= mask_n;
				end else begin
					pend_q <= pend_n;
				end
			end
		end
	end

`ifndef SYNTH
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eol |=> (marked_q == '0) && (acc_q == '0) && !pend_q)
		else $error("parser state not cleared after end of list");

	a_flag_not_reversed: assert property (@(posedge clk) disable iff (!arst_n)
		has_result && res.out_of_range |-> res.range_first <= res.range_final)
		else $error("out_of_range flagged on a reversed range");

	a_no_high_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(marked_q & ~VALID_BITS) == '0)
		else $error("bitmap holds a core at or beyond CORES");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(marked_q) && $stable(acc_q) && $stable(pend_q))
		else $error("parser state changed without a transaction");
`endif

endmodule

// ----- hdl/clrp_out_stage.sv -----
// Result register of the CPU list range parser.
`timescale 1ns / 1ps
module clrp_out_stage
	import clrp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	output logic    free,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic valid_q;

	assign free         = !valid_q || result_ready;
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result <= res;
		end
	end

endmodule

// ----- hdl/cpu_list_range_parser_unit.sv -----
// CPU list range parser: one character a cycle in, one result a commit out;
// a transaction passes the input and output registers. A character
// enters the input register, is decoded and committed into the core
// bitmap by combinational logic, and the result lands in the output register;
// a new character is taken every cycle as long as results are drained. A
// comma, a space or an end-of-list character produces a result; digits,
// hyphens and other characters produce none unless they end the list.
`timescale 1ns / 1ps
module cpu_list_range_parser_unit
	import clrp_pkg::*;
#(
	parameter int CORES = CORES_DEF
)
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic    valid_s1;
	item_t   item_s1;
	logic    has_result;
	result_t res;
	logic    free;
	logic    advance;

	// advance when the character yields nothing or the result slot is open
	assign advance = valid_s1 && (!has_result || free);

	clrp_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	clrp_core #(.CORES(CORES)) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_s1    (item_s1),
		.fire       (advance),
		.has_result (has_result),
		.res        (res)
	);

	clrp_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && has_result),
		.res          (res),
		.free         (free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ----- sim/cpu_list_range_parser_unit_tb.sv -----
// Self-checking testbench of the CPU list range parser: directed table, then random lists.
`timescale 1ns / 1ps
module cpu_list_range_parser_unit_tb;
	import clrp_pkg::*;

	localparam int NCORES       = CORES_DEF;
	localparam int RAND_ITEMS   = 1000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 500_000;

	localparam logic [7:0] SYM_OTHER = 8'h78;
	localparam logic [7:0] SYM_TOP   = 8'hFF;
	localparam logic [7:0] SYM_NUL   = 8'h00;

	typedef struct {
		item_t   stim;
		bit      typed;
		result_t want;
	} dir_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	// parser shadow state
	logic [VAL_W-1:0]  acc_val = '0;
	logic [VAL_W-1:0]  lo_val = '0;
	logic [VAL_W-1:0]  hi_val = '0;
	logic              hyphen_seen = 1'b0;
	logic [MASK_W-1:0] marked = '0;

	result_t  commit_q[$];
	dir_row_t dir_q[$];
	item_t    char_q[$];
	int       errors = 0;
	int       cycles = 0;
	bit       hold_req = 1'b0;

	cpu_list_range_parser_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] digit_sym(int d);
		return SYM_ZERO + d[7:0];
	endfunction

	function automatic void commit_span(output result_t res, input logic done);
		int first;
		int last;
		int top;
		logic flag;
		first = int'(lo_val);
		last = hyphen_seen ? int'(hi_val) : int'(lo_val);
		flag = 1'b0;
		if (first <= last) begin
			if (last >= NCORES) flag = 1'b1;
			if (first < NCORES) begin
				top = (last >= NCORES) ? NCORES - 1 : last;
				for (int i = 0; i < NCORES; i++)
					if (i >= first && i <= top) marked[i] = 1'b1;
			end
		end
		hyphen_seen = 1'b0;
		res.range_first = first[VAL_W-1:0];
		res.range_final = last[VAL_W-1:0];
		res.core_mask = marked;
		res.out_of_range = flag;
		res.list_done = done;
	endfunction

	// Advance the shadow parser by one character; return 1 when it commits.
	function automatic bit parse_char(input item_t it, output result_t res);
		int v;
		bit got;
		got = 1'b0;
		res = '0;
		if (it.symbol >= SYM_ZERO && it.symbol <= SYM_NINE) begin
			v = int'(acc_val) * 10 + int'(it.symbol - SYM_ZERO);
			acc_val = (v > int'(ACC_MAX)) ? ACC_MAX : v[VAL_W-1:0];
			if (hyphen_seen) hi_val = acc_val;
			else lo_val = acc_val;
		end else if (it.symbol == SYM_HYPHEN) begin
			acc_val = '0;
			hyphen_seen = 1'b1;
		end else if (it.symbol == SYM_COMMA || it.symbol == SYM_SPACE) begin
			acc_val = '0;
			commit_span(res, it.end_of_list);
			got = 1'b1;
		end
		if (it.end_of_list) begin
			if (!got) commit_span(res, 1'b1);
			got = 1'b1;
			acc_val = '0;
			lo_val = '0;
			hi_val = '0;
			hyphen_seen = 1'b0;
			marked = '0;
		end
		return got;
	endfunction

	function automatic bit is_live(item_t it);
		return it.end_of_list || it.symbol == SYM_HYPHEN || it.symbol == SYM_COMMA ||
			it.symbol == SYM_SPACE || (it.symbol >= SYM_ZERO && it.symbol <= SYM_NINE);
	endfunction

	task automatic add_row(logic [7:0] s, logic e, bit typed, int f, int l,
			logic [MASK_W-1:0] m, logic o, logic d);
		dir_row_t row;
		row.stim.symbol = s;
		row.stim.end_of_list = e;
		row.typed = typed;
		row.want.range_first = f[VAL_W-1:0];
		row.want.range_final = l[VAL_W-1:0];
		row.want.core_mask = m;
		row.want.out_of_range = o;
		row.want.list_done = d;
		dir_q.push_back(row);
	endtask

	// Offer one transaction after an idle gap and hold it until accepted.
	task automatic send_char(item_t it, int gap);
		if (gap > 0) begin
			@(negedge clk) item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	task automatic push_char(logic [7:0] s);
		item_t it;
		it.symbol = s;
		it.end_of_list = 1'b0;
		char_q.push_back(it);
	endtask

	task automatic push_number();
		int v;
		int r;
		int digs[$];
		r = $urandom_range(0, 99);
		if (r < 70) v = $urandom_range(0, 70);
		else if (r < 90) v = $urandom_range(0, 1023);
		else v = $urandom_range(10000, 99999);
		if ($urandom_range(0, 9) == 0) push_char(SYM_ZERO);
		do begin
			digs.push_front(v % 10);
			v = v / 10;
		end while (v > 0);
		foreach (digs[i]) begin
			if ($urandom_range(0, 24) == 0) push_char(8'($urandom_range(0, 255)));
			push_char(digit_sym(digs[i]));
		end
	endtask

	task automatic push_sep();
		push_char($urandom_range(0, 1) ? SYM_COMMA : SYM_SPACE);
	endtask

	// Build one list: mostly well formed, sometimes a jumble of symbols.
	task automatic build_list();
		int n;
		int pick;
		item_t it;
		char_q.delete();
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 8);
			for (int k = 0; k < n; k++) begin
				pick = $urandom_range(0, 4);
				case (pick)
					0: push_char(digit_sym($urandom_range(0, 9)));
					1: push_char(SYM_HYPHEN);
					2: push_char(SYM_COMMA);
					3: push_char(SYM_SPACE);
					default: push_char(8'($urandom_range(0, 255)));
				endcase
			end
		end else begin
			n = $urandom_range(1, 6);
			for (int e = 0; e < n; e++) begin
				push_number();
				if ($urandom_range(0, 99) < 45) begin
					push_char(SYM_HYPHEN);
					push_number();
				end
				if (e < n - 1) begin
					push_sep();
					if ($urandom_range(0, 4) == 0) push_sep();
				end
			end
			if ($urandom_range(0, 1)) push_sep();
		end
		it = char_q[char_q.size() - 1];
		it.end_of_list = 1'b1;
		char_q[char_q.size() - 1] = it;
	endtask

	task automatic wait_drained();
		@(negedge clk) item_valid <= 1'b0;
		while (commit_q.size() != 0) @(posedge clk);
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
				stall_left = 0;
			end else if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				result_ready <= 1'b1;
				if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
			end
		end
	end

	// Compare each result transaction with the oldest predicted commit.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (commit_q.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				want = commit_q.pop_front();
				if (result.range_first !== want.range_first) begin
					$error("range_first: expected %0d, got %0d",
						want.range_first, result.range_first);
					errors++;
				end
				if (result.range_final !== want.range_final) begin
					$error("range_final: expected %0d, got %0d",
						want.range_final, result.range_final);
					errors++;
				end
				if (result.core_mask !== want.core_mask) begin
					$error("core_mask: expected %h, got %h", want.core_mask, result.core_mask);
					errors++;
				end
				if (result.out_of_range !== want.out_of_range) begin
					$error("out_of_range: expected %0d, got %0d",
						want.out_of_range, result.out_of_range);
					errors++;
				end
				if (result.list_done !== want.list_done) begin
					$error("list_done: expected %0d, got %0d",
						want.list_done, result.list_done);
					errors++;
				end
			end
		end
	end

	initial begin
		result_t pred;
		bit got;
		bit quiet;
		int counted;
		int lists;
		int gap;

		counted = 0;
		lists = 0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// single zero right after reset
		add_row(SYM_COMMA, 1'b0, 1'b1, 0, 0, 64'h1, 1'b0, 1'b0);
		add_row(digit_sym(6), 1'b0, 1'b0, 0, 0, '0, 1'b0, 1'b0);
		add_row(digit_sym(3), 1'b0, 1'b0, 0, 0, '0, 1'b0, 1'b0);
		add_row(SYM_SPACE, 1'b0, 1'b1, 63, 63, 64'h8000_0000_0000_0001, 1'b0, 1'b0);
		// first core past the top
		add_row(digit_sym(6), 1'b0, 1'b0, 0, 0, '0, 1'b0, 1'b0);
		add_row(digit_sym(4), 1'b0, 1'b0, 0, 0, '0, 1'b0, 1'b0);
		add_row(SYM_COMMA, 1'b0, 1'b1, 64, 64, 64'h8000_0000_0000_0001, 1'b1, 1'b0);
		// saturated start, reversed range
		for (int k = 0; k < 4; k++) add_row(digit_sym(9), 1'b0, 1'b0, 0, 0, '0, 1'b0, 1'b0);
		add_row(SYM_HYPHEN, 1'b0, 1'b0, 0, 0, '0, 1'b0, 1'b0);
		add_row(digit_sym(5), 1'b0, 1'b0, 0, 0, '0, 1'b0, 1'b0);
		add_row(SYM_COMMA, 1'b0, 1'b1, 1023, 5, 64'h8000_0000_0000_0001, 1'b0, 1'b0);
		// range to the saturated end, closing the list on a separator
		add_row(digit_sym(1), 1'b0, 1'b0, 0, 0, '0, 1'b0, 1'b0);
		add_row(SYM_HYPHEN, 1'b0, 1'b0, 0, 0, '0, 1'b0, 1'b0);
		for (int k = 0; k < 4; k++) add_row(digit_sym(9), 1'b0, 1'b0, 0, 0, '0, 1'b0, 1'b0);
		add_row(SYM_SPACE, 1'b1, 1'b1, 1, 1023, '1, 1'b1, 1'b1);
		// ignored characters, alone and ending a list
		add_row(SYM_OTHER, 1'b0, 1'b0, 0, 0, '0, 1'b0, 1'b0);
		add_row(SYM_TOP, 1'b1, 1'b1, 0, 0, 64'h1, 1'b0, 1'b1);
		add_row(SYM_HYPHEN, 1'b1, 1'b1, 0, 0, 64'h1, 1'b0, 1'b1);
		add_row(digit_sym(5), 1'b1, 1'b1, 5, 5, 64'h20, 1'b0, 1'b1);
		add_row(SYM_NUL, 1'b0, 1'b0, 0, 0, '0, 1'b0, 1'b0);
		add_row(SYM_COMMA, 1'b0, 1'b1, 0, 0, 64'h1, 1'b0, 1'b0);

		foreach (dir_q[i]) begin
			send_char(dir_q[i].stim, pick_gap());
			got = parse_char(dir_q[i].stim, pred);
			if (dir_q[i].typed) commit_q.push_back(dir_q[i].want);
			else if (got) commit_q.push_back(pred);
		end

		while (counted < RAND_ITEMS) begin
			build_list();
			quiet = ($urandom_range(0, 4) == 0);
			if (lists == 15) hold_req = 1'b1;
			if (lists == 30 || $urandom_range(0, 19) == 0) wait_drained();
			foreach (char_q[i]) begin
				gap = quiet ? 0 : pick_gap();
				send_char(char_q[i], gap);
				if (parse_char(char_q[i], pred)) commit_q.push_back(pred);
				if (is_live(char_q[i])) counted++;
			end
			lists++;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
